### rtl/http_chunked_body_decoder_top_defines.svh
// Assertion macros used by the chunked body decoder top level.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HCBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hcbd assertion failed");

// Next-cycle implication, checked outside reset.
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hcbd assertion failed");

`endif

### rtl/hcbd_pkg.sv
// Types, constants and byte classification for the chunked body decoder.
`timescale 1ns / 1ps
package hcbd_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_HT   = 8'h09;

    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Byte classes seen by the parser
    typedef enum logic [2:0] {
        CLS_HEX   = 3'd0,
        CLS_SEMI  = 3'd1,
        CLS_CR    = 3'd2,
        CLS_LF    = 3'd3,
        CLS_WS    = 3'd4,
        CLS_OTHER = 3'd5
    } t_cls;

    // One classified byte as it travels through the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_message;
        t_cls       cls;
        logic [3:0] hex;
    } t_item;

    localparam int ITEM_BITS = $bits(t_item);

    // Parser phases, one-hot
    typedef enum logic [12:0] {
        PH_SIZE        = 13'b0000000000001,
        PH_SIZE_CR     = 13'b0000000000010,
        PH_EXT         = 13'b0000000000100,
        PH_EXT_CR      = 13'b0000000001000,
        PH_DATA        = 13'b0000000010000,
        PH_DATA_CR     = 13'b0000000100000,
        PH_DATA_LF     = 13'b0000001000000,
        PH_TR_START    = 13'b0000010000000,
        PH_TR_START_CR = 13'b0000100000000,
        PH_TR_LINE     = 13'b0001000000000,
        PH_TR_CR       = 13'b0010000000000,
        PH_DONE        = 13'b0100000000000,
        PH_ERROR       = 13'b1000000000000
    } t_phase;

    // Sort a raw byte into its class
    function automatic t_cls classify(input logic [7:0] c);
        t_cls cls;
        if (c == CH_SEMI) begin
            cls = CLS_SEMI;
        end else if (c == CH_CR) begin
            cls = CLS_CR;
        end else if (c == CH_LF) begin
            cls = CLS_LF;
        end else if (c == CH_SP || c == CH_HT) begin
            cls = CLS_WS;
        end else if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                     (c >= 8'h61 && c <= 8'h66)) begin
            cls = CLS_HEX;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

    // Value of a hex digit; zero for anything else
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = c[3:0] + 4'd9;
        end else begin
            v = 4'd0;
        end
        return v;
    endfunction

endpackage

### rtl/hcbd_if.sv
// Valid/ready channel interfaces for raw input bytes and decoded results.
`timescale 1ns / 1ps
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_message;

    modport source (output valid, output data_byte, output new_message, input ready);
    modport sink   (input valid, input data_byte, input new_message, output ready);
endinterface

interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       chunk_end;
    logic       consumed;
    logic [1:0] status;

    modport source (output valid, output payload_valid, output payload_byte,
                    output chunk_end, output consumed, output status, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input chunk_end, input consumed, input status, output ready);
endinterface

### rtl/hcbd_queue.sv
// Small register queue between the classifier and the parser.
`timescale 1ns / 1ps
module hcbd_queue #(
    parameter int DEPTH = hcbd_pkg::QUEUE_DEPTH,
    parameter int WIDTH = hcbd_pkg::ITEM_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers with wrap, track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/hcbd_front.sv
// Front end: accepts raw byte requests and classifies them for the parser.
`timescale 1ns / 1ps
module hcbd_front (
    hcbd_in_if.sink         i_req,
    input  logic            i_q_ready,
    output logic            o_push,
    output hcbd_pkg::t_item o_item
);

    // Take a request whenever the queue has room
    assign i_req.ready = i_q_ready;
    assign o_push      = i_req.valid && i_q_ready;

    // Classify the byte
    always_comb begin
        o_item.data_byte   = i_req.data_byte;
        o_item.new_message = i_req.new_message;
        o_item.cls         = hcbd_pkg::classify(i_req.data_byte);
        o_item.hex         = hcbd_pkg::hex_value(i_req.data_byte);
    end

endmodule

### rtl/hcbd_back.sv
// Back end: chunked framing state machine and registered result stage.
`timescale 1ns / 1ps
module hcbd_back #(
    parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_emit_payload,
    input  logic            i_q_valid,
    input  hcbd_pkg::t_item i_item,
    output logic            o_pop,
    hcbd_out_if.source      o_rsp
);

    hcbd_pkg::t_phase      r_phase, n_phase, cur_phase;
    logic [COUNT_BITS-1:0] r_bytes_left, n_bytes_left, cur_bytes_left, dec_bytes_left;
    logic                  r_digit_seen, n_digit_seen, cur_digit_seen;

    logic                  r_valid;
    logic                  r_pv, n_pv;
    logic [7:0]            r_pb, n_pb;
    logic                  r_ce, n_ce;
    logic                  r_took, n_took;
    logic [1:0]            r_status, n_status;

    // Pop when the result register is free or being drained
    assign o_pop = i_q_valid && (!r_valid || o_rsp.ready);

    // Step the parser by one byte
    always_comb begin
        cur_phase      = i_item.new_message ? hcbd_pkg::PH_SIZE : r_phase;
        cur_bytes_left = i_item.new_message ? '0 : r_bytes_left;
        cur_digit_seen = i_item.new_message ? 1'b0 : r_digit_seen;
        dec_bytes_left = (cur_bytes_left != '0) ? cur_bytes_left - COUNT_BITS'(1)
                                                : cur_bytes_left;

        n_phase      = cur_phase;
        n_bytes_left = cur_bytes_left;
        n_digit_seen = cur_digit_seen;
        n_pv         = 1'b0;
        n_pb         = 8'd0;
        n_ce         = 1'b0;
        n_took       = 1'b1;

        case (cur_phase)
            hcbd_pkg::PH_SIZE: begin
                case (i_item.cls)
                    hcbd_pkg::CLS_SEMI: begin
                        if (!cur_digit_seen) begin
                            n_phase = hcbd_pkg::PH_ERROR;
                            n_took  = 1'b0;
                        end else begin
                            n_phase = hcbd_pkg::PH_EXT;
                        end
                    end
                    hcbd_pkg::CLS_CR: begin
                        n_phase = hcbd_pkg::PH_SIZE_CR;
                    end
                    hcbd_pkg::CLS_WS: begin
                        n_phase = cur_phase;
                    end
                    hcbd_pkg::CLS_HEX: begin
                        // Reject a digit that would shift bits out of the count
                        if (cur_bytes_left[COUNT_BITS-1 -: 4] != 4'd0) begin
                            n_phase = hcbd_pkg::PH_ERROR;
                            n_took  = 1'b0;
                        end else begin
                            n_bytes_left = {cur_bytes_left[COUNT_BITS-5:0], i_item.hex};
                            n_digit_seen = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = hcbd_pkg::PH_ERROR;
                        n_took  = 1'b0;
                    end
                endcase
            end
            hcbd_pkg::PH_SIZE_CR: begin
                if (i_item.cls != hcbd_pkg::CLS_LF || !cur_digit_seen) begin
                    n_phase = hcbd_pkg::PH_ERROR;
                    n_took  = 1'b0;
                end else begin
                    n_phase = (cur_bytes_left == '0) ? hcbd_pkg::PH_TR_START
                                                     : hcbd_pkg::PH_DATA;
                end
            end
            hcbd_pkg::PH_EXT: begin
                if (i_item.cls == hcbd_pkg::CLS_CR) begin
                    n_phase = hcbd_pkg::PH_EXT_CR;
                end
            end
            hcbd_pkg::PH_EXT_CR: begin
                if (i_item.cls == hcbd_pkg::CLS_LF) begin
                    n_phase = (cur_bytes_left == '0) ? hcbd_pkg::PH_TR_START
                                                     : hcbd_pkg::PH_DATA;
                end else if (i_item.cls != hcbd_pkg::CLS_CR) begin
                    n_phase = hcbd_pkg::PH_EXT;
                end
            end
            hcbd_pkg::PH_DATA: begin
                n_bytes_left = dec_bytes_left;
                if (i_emit_payload) begin
                    n_pv = 1'b1;
                    n_pb = i_item.data_byte;
                    n_ce = (dec_bytes_left == '0);
                end
                if (dec_bytes_left == '0) begin
                    n_phase = hcbd_pkg::PH_DATA_CR;
                end
            end
            hcbd_pkg::PH_DATA_CR: begin
                if (i_item.cls == hcbd_pkg::CLS_CR) begin
                    n_phase = hcbd_pkg::PH_DATA_LF;
                end else begin
                    n_phase = hcbd_pkg::PH_ERROR;
                    n_took  = 1'b0;
                end
            end
            hcbd_pkg::PH_DATA_LF: begin
                if (i_item.cls == hcbd_pkg::CLS_LF) begin
                    n_phase      = hcbd_pkg::PH_SIZE;
                    n_bytes_left = '0;
                    n_digit_seen = 1'b0;
                end else begin
                    n_phase = hcbd_pkg::PH_ERROR;
                    n_took  = 1'b0;
                end
            end
            hcbd_pkg::PH_TR_START: begin
                n_phase = (i_item.cls == hcbd_pkg::CLS_CR) ? hcbd_pkg::PH_TR_START_CR
                                                           : hcbd_pkg::PH_TR_LINE;
            end
            hcbd_pkg::PH_TR_START_CR: begin
                if (i_item.cls == hcbd_pkg::CLS_LF) begin
                    n_phase = hcbd_pkg::PH_DONE;
                end else if (i_item.cls == hcbd_pkg::CLS_CR) begin
                    n_phase = hcbd_pkg::PH_TR_CR;
                end else begin
                    n_phase = hcbd_pkg::PH_TR_LINE;
                end
            end
            hcbd_pkg::PH_TR_LINE: begin
                if (i_item.cls == hcbd_pkg::CLS_CR) begin
                    n_phase = hcbd_pkg::PH_TR_CR;
                end
            end
            hcbd_pkg::PH_TR_CR: begin
                if (i_item.cls == hcbd_pkg::CLS_LF) begin
                    n_phase = hcbd_pkg::PH_TR_START;
                end else if (i_item.cls != hcbd_pkg::CLS_CR) begin
                    n_phase = hcbd_pkg::PH_TR_LINE;
                end
            end
            hcbd_pkg::PH_DONE: begin
                n_took = 1'b0;
            end
            default: begin
                // Error, or any code outside the list: hold error
                n_phase = hcbd_pkg::PH_ERROR;
                n_took  = 1'b0;
            end
        endcase

        if (n_phase == hcbd_pkg::PH_DONE) begin
            n_status = hcbd_pkg::ST_DONE;
        end else if (n_phase == hcbd_pkg::PH_ERROR) begin
            n_status = hcbd_pkg::ST_ERROR;
        end else begin
            n_status = hcbd_pkg::ST_BUSY;
        end
    end

    // Hold parser state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= hcbd_pkg::PH_SIZE;
            r_bytes_left <= '0;
            r_digit_seen <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase      <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_digit_seen <= n_digit_seen;
                r_valid      <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid      <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pv     <= n_pv;
            r_pb     <= n_pb;
            r_ce     <= n_ce;
            r_took   <= n_took;
            r_status <= n_status;
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.payload_valid = r_pv;
    assign o_rsp.payload_byte  = r_pb;
    assign o_rsp.chunk_end     = r_ce;
    assign o_rsp.consumed      = r_took;
    assign o_rsp.status        = r_status;

endmodule

### rtl/http_chunked_body_decoder_top.sv
// Top level of the HTTP/1.1 chunked body decoder.
//
// Usage:
//   i_req carries one raw body byte per request (data_byte, new_message);
//   new_message restarts the parser before that byte is handled.
//   o_rsp returns exactly one result per request, in order: the decoded
//   payload byte with its chunk_end flag, whether the byte was consumed,
//   and the status (in progress, done, format error) after that byte.
//   i_cfg_we / i_cfg_data write emit_payload (reset 1); write it only while
//   no request is outstanding. With emit_payload 0 body bytes are dropped.
// Timing:
//   One request per cycle sustained while o_rsp keeps taking results. A
//   request is classified as it is accepted and written into a two-entry
//   queue; the parser pops it when the result register is free or being
//   drained and steps it into that register, where it waits for o_rsp. The
//   rate is set by the parser step over the one-hot phase register.
// Reset and stall:
//   Synchronous active-low reset empties the queue and result register and
//   puts the parser at the start of a size line. While o_rsp is stalled the
//   queue keeps taking requests until it is full, then i_req.ready drops.
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_top_defines.svh"
module http_chunked_body_decoder_top #(
    parameter int COUNT_BITS  = hcbd_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = hcbd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbd_in_if.sink     i_req,
    hcbd_out_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data
);

    logic                           r_emit_payload;
    logic                           q_push;
    logic                           q_ready;
    logic                           q_pop;
    logic                           q_valid;
    hcbd_pkg::t_item                push_item;
    logic [hcbd_pkg::ITEM_BITS-1:0] pop_data;

    // Hold the payload emit setting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_payload <= 1'b1;
        end else if (i_cfg_we) begin
            r_emit_payload <= i_cfg_data;
        end
    end

    hcbd_front u_front (
        .i_req     (i_req),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_item    (push_item)
    );

    hcbd_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (hcbd_pkg::ITEM_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (pop_data)
    );

    hcbd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_emit_payload (r_emit_payload),
        .i_q_valid      (q_valid),
        .i_item         (hcbd_pkg::t_item'(pop_data)),
        .o_pop          (q_pop),
        .o_rsp          (o_rsp)
    );

    // A byte that was not consumed means the parser is done or failed
    `HCBD_ASSERT_IMPL(a_unconsumed_final, i_clk, i_rst_n, o_rsp.valid && !o_rsp.consumed, o_rsp.status == hcbd_pkg::ST_DONE || o_rsp.status == hcbd_pkg::ST_ERROR)
    // Emitted payload is always a consumed byte of a message in progress
    `HCBD_ASSERT_IMPL(a_payload_busy, i_clk, i_rst_n, o_rsp.valid && o_rsp.payload_valid, o_rsp.consumed && o_rsp.status == hcbd_pkg::ST_BUSY)
    // Chunk end only marks an emitted byte
    `HCBD_ASSERT_IMPL(a_chunk_end_payload, i_clk, i_rst_n, o_rsp.valid && o_rsp.chunk_end, o_rsp.payload_valid)
    // An accepted request sits in the queue on the next cycle
    `HCBD_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, i_req.valid && i_req.ready, q_valid)

endmodule

### bench/tb_http_chunked_body_decoder_top.sv
// Self-checking testbench for the chunked body decoder: directed table, then random messages.
`timescale 1ns / 1ps
module tb_http_chunked_body_decoder_top;

    localparam int CNT_W        = hcbd_pkg::COUNT_BITS_DEF;
    localparam int IDLE_PCT     = 34;
    localparam int HOLD_CYCLES  = 48;
    localparam int SETTLE       = 6;
    localparam int PHASE_BYTES  = 262;
    localparam int CYCLE_LIMIT  = 200000;

    // One decoded result as seen on the response channel
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       chunk_end;
        logic       consumed;
        logic [1:0] status;
    } t_dec_result;

    // One row of the directed table; want is used only when typed is set
    typedef struct {
        logic [7:0]  data_byte;
        logic        new_message;
        bit          typed;
        t_dec_result want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;

    hcbd_in_if  byte_in ();
    hcbd_out_if result_out ();

    http_chunked_body_decoder_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (byte_in),
        .o_rsp      (result_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Decoder state mirrored by the predictor
    hcbd_pkg::t_phase dec_phase;
    logic [CNT_W-1:0] dec_left;
    logic             dec_digit_seen;
    logic             dec_last_chunk;
    logic             dec_emit;

    t_dec_result expected_results[$];
    t_stim_row   directed_rows[$];
    logic [7:0]  msg_q[$];

    bit no_idle;
    bit hold_off_req;
    int cycle_count;
    int fail_count;
    int bytes_sent;
    int results_checked;
    int payload_count;
    int done_count;
    int error_count;

    // Clock: 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic t_dec_result make_result(input logic pv, input logic [7:0] pb,
                                                input logic ce, input logic took,
                                                input logic [1:0] st);
        t_dec_result r;
        r.payload_valid = pv;
        r.payload_byte  = pb;
        r.chunk_end     = ce;
        r.consumed      = took;
        r.status        = st;
        return r;
    endfunction

    // Return {is_hex, value} for one byte
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9") begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (c >= "a" && c <= "f") begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        if (c >= "A" && c <= "F") begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic void restart_decoder();
        dec_phase      = hcbd_pkg::PH_SIZE;
        dec_left       = '0;
        dec_digit_seen = 1'b0;
        dec_last_chunk = 1'b0;
    endfunction

    // Size line complete: payload follows, or the trailer section on a zero size
    function automatic void finish_size_line();
        if (dec_left == '0) begin
            dec_last_chunk = 1'b1;
            dec_phase      = hcbd_pkg::PH_TR_START;
        end else begin
            dec_phase = hcbd_pkg::PH_DATA;
        end
    endfunction

    // Advance the mirrored decoder by one byte and return its result
    function automatic t_dec_result decode_byte(input logic [7:0] c, input logic nm);
        t_dec_result r;
        logic [4:0]  nib;
        r = '0;
        r.consumed = 1'b1;
        nib = hex_nibble(c);
        if (nm) restart_decoder();
        case (dec_phase)
            hcbd_pkg::PH_SIZE: begin
                if (c == hcbd_pkg::CH_SEMI) begin
                    if (!dec_digit_seen) begin
                        dec_phase  = hcbd_pkg::PH_ERROR;
                        r.consumed = 1'b0;
                    end else begin
                        dec_phase = hcbd_pkg::PH_EXT;
                    end
                end else if (c == hcbd_pkg::CH_CR) begin
                    dec_phase = hcbd_pkg::PH_SIZE_CR;
                end else if (c == hcbd_pkg::CH_SP || c == hcbd_pkg::CH_HT) begin
                    // skip whitespace
                end else if (!nib[4] || dec_left[CNT_W-1 -: 4] != 4'd0) begin
                    // bad character, or the shift would lose the top digit
                    dec_phase  = hcbd_pkg::PH_ERROR;
                    r.consumed = 1'b0;
                end else begin
                    dec_left       = {dec_left[CNT_W-5:0], nib[3:0]};
                    dec_digit_seen = 1'b1;
                end
            end
            hcbd_pkg::PH_SIZE_CR: begin
                if (c != hcbd_pkg::CH_LF || !dec_digit_seen) begin
                    dec_phase  = hcbd_pkg::PH_ERROR;
                    r.consumed = 1'b0;
                end else begin
                    finish_size_line();
                end
            end
            hcbd_pkg::PH_EXT: begin
                if (c == hcbd_pkg::CH_CR) dec_phase = hcbd_pkg::PH_EXT_CR;
            end
            hcbd_pkg::PH_EXT_CR: begin
                if (c == hcbd_pkg::CH_LF) finish_size_line();
                else if (c != hcbd_pkg::CH_CR) dec_phase = hcbd_pkg::PH_EXT;
            end
            hcbd_pkg::PH_DATA: begin
                if (dec_left != '0) dec_left = dec_left - 1'b1;
                if (dec_emit) begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = c;
                    r.chunk_end     = (dec_left == '0);
                end
                if (dec_left == '0) dec_phase = hcbd_pkg::PH_DATA_CR;
            end
            hcbd_pkg::PH_DATA_CR: begin
                if (c == hcbd_pkg::CH_CR) begin
                    dec_phase = hcbd_pkg::PH_DATA_LF;
                end else begin
                    dec_phase  = hcbd_pkg::PH_ERROR;
                    r.consumed = 1'b0;
                end
            end
            hcbd_pkg::PH_DATA_LF: begin
                if (c == hcbd_pkg::CH_LF) begin
                    dec_phase      = hcbd_pkg::PH_SIZE;
                    dec_left       = '0;
                    dec_digit_seen = 1'b0;
                end else begin
                    dec_phase  = hcbd_pkg::PH_ERROR;
                    r.consumed = 1'b0;
                end
            end
            hcbd_pkg::PH_TR_START: begin
                dec_phase = (c == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_TR_START_CR
                                                   : hcbd_pkg::PH_TR_LINE;
            end
            hcbd_pkg::PH_TR_START_CR: begin
                if (c == hcbd_pkg::CH_LF) dec_phase = hcbd_pkg::PH_DONE;
                else if (c == hcbd_pkg::CH_CR) dec_phase = hcbd_pkg::PH_TR_CR;
                else dec_phase = hcbd_pkg::PH_TR_LINE;
            end
            hcbd_pkg::PH_TR_LINE: begin
                if (c == hcbd_pkg::CH_CR) dec_phase = hcbd_pkg::PH_TR_CR;
            end
            hcbd_pkg::PH_TR_CR: begin
                if (c == hcbd_pkg::CH_LF) dec_phase = hcbd_pkg::PH_TR_START;
                else if (c != hcbd_pkg::CH_CR) dec_phase = hcbd_pkg::PH_TR_LINE;
            end
            hcbd_pkg::PH_DONE: begin
                r.consumed = 1'b0;
            end
            default: begin
                dec_phase  = hcbd_pkg::PH_ERROR;
                r.consumed = 1'b0;
            end
        endcase
        r.status = (dec_phase == hcbd_pkg::PH_DONE)  ? hcbd_pkg::ST_DONE :
                   (dec_phase == hcbd_pkg::PH_ERROR) ? hcbd_pkg::ST_ERROR :
                                                       hcbd_pkg::ST_BUSY;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request, hold it until taken, then record what it must produce
    task automatic send_item(input logic [7:0] c, input logic nm, input bit typed,
                             input t_dec_result want);
        t_dec_result predicted;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            byte_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_in.valid       <= 1'b1;
        byte_in.data_byte   <= c;
        byte_in.new_message <= nm;
        do @(posedge i_clk); while (!byte_in.ready);
        predicted = decode_byte(c, nm);
        expected_results.push_back(typed ? want : predicted);
        bytes_sent++;
    endtask

    // Drop valid and wait until every request has its result
    task automatic wait_for_results();
        @(negedge i_clk);
        byte_in.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_emit_payload(input logic v);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        dec_emit = v;
    endtask

    function automatic void add_row(input logic [7:0] c, input logic nm = 1'b0,
                                    input bit typed = 1'b0, input t_dec_result want = '0);
        t_stim_row r;
        r.data_byte   = c;
        r.new_message = nm;
        r.typed       = typed;
        r.want        = want;
        directed_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Random message builder
    // ------------------------------------------------------------------

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return ($urandom_range(1) ? 8'h37 : 8'h57) + v;
    endfunction

    function automatic logic [7:0] any_byte_but(input logic [7:0] ex);
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == ex);
        return b;
    endfunction

    function automatic void add_ws();
        if ($urandom_range(5) == 0)
            msg_q.push_back($urandom_range(1) ? hcbd_pkg::CH_SP : hcbd_pkg::CH_HT);
    endfunction

    function automatic void add_crlf();
        msg_q.push_back(hcbd_pkg::CH_CR);
        msg_q.push_back(hcbd_pkg::CH_LF);
    endfunction

    // Size line with optional leading zeros, whitespace and extension
    function automatic void add_size_line(input logic [31:0] size);
        int top;
        top = 7;
        while (top > 0 && size[top*4 +: 4] == 4'd0) top--;
        add_ws();
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) msg_q.push_back("0");
        for (int k = top; k >= 0; k--) begin
            msg_q.push_back(hex_char(size[k*4 +: 4]));
            add_ws();
        end
        if ($urandom_range(3) == 0) begin
            msg_q.push_back(hcbd_pkg::CH_SEMI);
            repeat ($urandom_range(5)) msg_q.push_back(any_byte_but(hcbd_pkg::CH_CR));
            // lone CR inside the extension
            if ($urandom_range(2) == 0) begin
                msg_q.push_back(hcbd_pkg::CH_CR);
                msg_q.push_back("x");
            end
        end
        add_crlf();
    endfunction

    function automatic void add_trailer_line();
        if ($urandom_range(4) == 0) begin
            msg_q.push_back(hcbd_pkg::CH_CR);
            msg_q.push_back("t");
        end else begin
            msg_q.push_back(any_byte_but(hcbd_pkg::CH_CR));
        end
        repeat ($urandom_range(5)) msg_q.push_back(any_byte_but(hcbd_pkg::CH_CR));
        add_crlf();
    endfunction

    // Mostly well-formed messages; the rest broken in one way or another
    function automatic void build_message();
        int kind;
        int size;
        int cut;
        msg_q.delete();
        kind = $urandom_range(99);
        if (kind >= 95) begin
            repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom_range(255)));
            return;
        end
        if (kind >= 89) begin
            if ($urandom_range(1)) begin
                // nine or ten digits with a nonzero lead: count overflow
                msg_q.push_back(hex_char(4'($urandom_range(1, 15))));
                repeat ($urandom_range(8, 9)) msg_q.push_back(hex_char(4'($urandom_range(15))));
            end else begin
                repeat (8) msg_q.push_back(hex_char(4'hF));
            end
            add_crlf();
            repeat (3) msg_q.push_back(8'($urandom_range(255)));
            return;
        end
        for (int k = 0; k < $urandom_range(3); k++) begin
            size = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            add_size_line(size);
            repeat (size) msg_q.push_back(8'($urandom_range(255)));
            if (kind >= 83) begin
                // wrong payload terminator
                if ($urandom_range(1)) begin
                    msg_q.push_back(any_byte_but(hcbd_pkg::CH_CR));
                end else begin
                    msg_q.push_back(hcbd_pkg::CH_CR);
                    msg_q.push_back(any_byte_but(hcbd_pkg::CH_LF));
                end
                return;
            end
            add_crlf();
        end
        add_size_line(0);
        repeat ($urandom_range(2)) add_trailer_line();
        add_crlf();
        if (kind >= 70 && kind < 77) begin
            msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom_range(255));
        end else if (kind >= 77 && kind < 83) begin
            cut = $urandom_range(1, msg_q.size() - 1);
            repeat (cut) void'(msg_q.pop_back());
        end else if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    task automatic send_message(input logic nm_first);
        for (int k = 0; k < msg_q.size(); k++)
            send_item(msg_q[k], (k == 0) ? nm_first : 1'b0, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Drive ready: random stalls, or a long hold-off on request
    initial begin : rsp_ready_gen
        int hold_left;
        hold_left = 0;
        result_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && hold_left == 0) begin
                hold_left    = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left != 0) begin
                result_out.ready <= 1'b0;
                hold_left--;
            end else begin
                result_out.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_dec_result want;
        if (i_rst_n && result_out.valid && result_out.ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request pending");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("payload_valid", want.payload_valid, result_out.payload_valid);
                check_field("payload_byte", want.payload_byte, result_out.payload_byte);
                check_field("chunk_end", want.chunk_end, result_out.chunk_end);
                check_field("consumed", want.consumed, result_out.consumed);
                check_field("status", want.status, result_out.status);
                results_checked++;
                if (want.payload_valid) payload_count++;
                if (want.status == hcbd_pkg::ST_DONE) done_count++;
                if (want.status == hcbd_pkg::ST_ERROR) error_count++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        int sent;
        byte_in.valid       = 1'b0;
        byte_in.data_byte   = 8'h00;
        byte_in.new_message = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_data          = 1'b0;
        i_rst_n             = 1'b0;
        no_idle             = 1'b0;
        hold_off_req        = 1'b0;
        cycle_count         = 0;
        fail_count          = 0;
        bytes_sent          = 0;
        results_checked     = 0;
        payload_count       = 0;
        done_count          = 0;
        error_count         = 0;
        dec_emit            = 1'b1;
        restart_decoder();

        // Full message: extension with a lone CR, one 0xFF payload byte,
        // whitespace in the last size line, a trailer line starting with a lone CR
        add_row("1", 1'b1, 1'b1, make_result(1'b0, 8'h00, 1'b0, 1'b1, hcbd_pkg::ST_BUSY));
        add_row(hcbd_pkg::CH_SEMI);
        add_row(hcbd_pkg::CH_CR);
        add_row("z");
        add_row(hcbd_pkg::CH_CR);
        add_row(hcbd_pkg::CH_LF);
        add_row(8'hFF, 1'b0, 1'b1, make_result(1'b1, 8'hFF, 1'b1, 1'b1, hcbd_pkg::ST_BUSY));
        add_row(hcbd_pkg::CH_CR);
        add_row(hcbd_pkg::CH_LF);
        add_row("0");
        add_row(hcbd_pkg::CH_HT);
        add_row(hcbd_pkg::CH_CR);
        add_row(hcbd_pkg::CH_LF);
        add_row(hcbd_pkg::CH_CR);
        add_row("T");
        add_row(hcbd_pkg::CH_CR);
        add_row(hcbd_pkg::CH_LF);
        add_row(hcbd_pkg::CH_CR);
        add_row(hcbd_pkg::CH_LF, 1'b0, 1'b1,
                make_result(1'b0, 8'h00, 1'b0, 1'b1, hcbd_pkg::ST_DONE));
        // byte after completion is refused
        add_row("A", 1'b0, 1'b1, make_result(1'b0, 8'h00, 1'b0, 1'b0, hcbd_pkg::ST_DONE));
        // bad size character, then an empty size before ';'
        add_row(8'h00, 1'b1, 1'b1, make_result(1'b0, 8'h00, 1'b0, 1'b0, hcbd_pkg::ST_ERROR));
        add_row(hcbd_pkg::CH_SEMI, 1'b1, 1'b1,
                make_result(1'b0, 8'h00, 1'b0, 1'b0, hcbd_pkg::ST_ERROR));
        // CR without LF in the size line
        add_row("b", 1'b1);
        add_row(hcbd_pkg::CH_CR);
        add_row(hcbd_pkg::CH_SP, 1'b0, 1'b1,
                make_result(1'b0, 8'h00, 1'b0, 1'b0, hcbd_pkg::ST_ERROR));
        // LF where the CR after the payload belongs
        add_row("1", 1'b1);
        add_row(hcbd_pkg::CH_CR);
        add_row(hcbd_pkg::CH_LF);
        add_row("d");
        add_row(hcbd_pkg::CH_LF, 1'b0, 1'b1,
                make_result(1'b0, 8'h00, 1'b0, 1'b0, hcbd_pkg::ST_ERROR));

        // Hold reset, then release it on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_item(directed_rows[k].data_byte, directed_rows[k].new_message,
                      directed_rows[k].typed, directed_rows[k].want);

        // Random messages under alternating payload settings
        for (int ph = 0; ph < 4; ph++) begin
            write_emit_payload(ph[0]);
            if (ph == 1) begin
                // back-to-back requests against a long result stall
                no_idle      = 1'b1;
                hold_off_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_message();
                send_message($urandom_range(31) != 0);
                sent += msg_q.size();
                if (ph == 1 && sent > 150) no_idle = 1'b0;
            end
        end

        wait_for_results();
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d request bytes over four payload settings; checked %0d results",
                 bytes_sent, results_checked);
        $display("  %0d payload bytes, %0d done and %0d error statuses seen",
                 payload_count, done_count, error_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/hcbd_pkg.sv
rtl/hcbd_if.sv
rtl/hcbd_queue.sv
rtl/hcbd_front.sv
rtl/hcbd_back.sv
rtl/http_chunked_body_decoder_top.sv
bench/tb_http_chunked_body_decoder_top.sv
